// ===== hw/rtl/lgrs_pkg.sv =====
`default_nettype none

package lgrs_pkg;

  // grid geometry
  localparam int MAX_WIDTH = 64;
  localparam int WIDTH_W   = 7;

  // job queue geometry
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  typedef logic [MAX_WIDTH-1:0] row_t;
  typedef logic [WIDTH_W-1:0]   width_t;

  // one queued job: the three rows around a result plus its mask and flags
  typedef struct packed {
    row_t up;
    row_t mid;
    row_t down;
    row_t mask;
    logic has_prev;
    logic last;
  } job_t;

  // live column mask for a configured width, saturating at the row width
  function automatic row_t live_mask(input width_t w);
    row_t m;
    if (int'(w) >= MAX_WIDTH) begin
      m = '1;
    end else begin
      m = (row_t'(1) << w) - row_t'(1);
    end
    return m;
  endfunction

  // one life generation (birth on three, survival on two or three)
  function automatic row_t evolve_row(input row_t up, input row_t mid,
                                      input row_t down, input row_t mask);
    row_t u;
    row_t m;
    row_t d;
    row_t res;
    logic [3:0] n;
    logic [2:0] nu;
    logic [2:0] nd;
    logic [1:0] nm;
    u = up & mask;
    m = mid & mask;
    d = down & mask;
    res = '0;
    for (int i = 0; i < MAX_WIDTH; i++) begin
      nu = {2'b00, u[i]};
      nd = {2'b00, d[i]};
      nm = 2'b00;
      if (i > 0) begin
        nu = nu + {2'b00, u[i-1]};
        nd = nd + {2'b00, d[i-1]};
        nm = nm + {1'b0, m[i-1]};
      end
      if (i < MAX_WIDTH - 1) begin
        nu = nu + {2'b00, u[i+1]};
        nd = nd + {2'b00, d[i+1]};
        nm = nm + {1'b0, m[i+1]};
      end
      n = {1'b0, nu} + {1'b0, nd} + {2'b00, nm};
      res[i] = (n == 4'd3) || ((n == 4'd2) && m[i]);
    end
    return res & mask;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/lgrs_front.sv =====
`default_nettype none

module lgrs_front (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire lgrs_pkg::width_t cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire lgrs_pkg::row_t  row_cells,
  input  wire                  last_row,
  output logic                 push,
  output lgrs_pkg::job_t       push_job,
  input  wire                  q_full
);

  lgrs_pkg::width_t grid_width;
  lgrs_pkg::row_t   row_above;
  lgrs_pkg::row_t   row_two_above;
  logic [1:0]       rows_seen;

  lgrs_pkg::row_t mask;
  lgrs_pkg::row_t row_m;
  logic           accept;

  // width register
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= lgrs_pkg::width_t'(lgrs_pkg::MAX_WIDTH);
    end else if (cfg_we) begin
      grid_width <= cfg_wdata;
    end
  end

  // classify the item and build its job
  always_comb begin
    mask     = lgrs_pkg::live_mask(grid_width);
    row_m    = row_cells & mask;
    in_stall = q_full;
    accept   = in_valid && !in_stall;
    push     = accept && ((rows_seen != 2'd0) || last_row);
    push_job.up       = rows_seen[1] ? (row_two_above & mask) : '0;
    push_job.mid      = (rows_seen != 2'd0) ? (row_above & mask) : '0;
    push_job.down     = row_m;
    push_job.mask     = mask;
    push_job.has_prev = (rows_seen != 2'd0);
    push_job.last     = last_row;
  end

  // row history, each row kept as masked on arrival
  always_ff @(posedge clk) begin
    if (rst) begin
      row_above     <= '0;
      row_two_above <= '0;
      rows_seen     <= 2'd0;
    end else if (accept) begin
      if (last_row) begin
        row_above     <= '0;
        row_two_above <= '0;
        rows_seen     <= 2'd0;
      end else begin
        row_two_above <= row_above;
        row_above     <= row_m;
        if (rows_seen != 2'd2) begin
          rows_seen <= rows_seen + 2'd1;
        end
      end
    end
  end

`ifndef SYNTHESIS
  a_seen_sat: assert property (@(posedge clk) disable iff (rst) rows_seen != 2'd3)
    else $error("row count passed two");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lgrs_queue.sv =====
`default_nettype none

module lgrs_queue (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  push,
  input  wire lgrs_pkg::job_t  push_job,
  output logic                 full,
  input  wire                  pop,
  output lgrs_pkg::job_t       head,
  output logic                 empty
);

  lgrs_pkg::job_t                slots [lgrs_pkg::QDEPTH];
  logic [lgrs_pkg::QPTR_W-1:0]   wr_ptr;
  logic [lgrs_pkg::QPTR_W-1:0]   rd_ptr;
  logic [lgrs_pkg::QCNT_W-1:0]   count;

  // status and head
  always_comb begin
    full  = (count == lgrs_pkg::QCNT_W'(lgrs_pkg::QDEPTH));
    empty = (count == '0);
    head  = slots[rd_ptr];
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

`ifndef SYNTHESIS
  a_no_overflow: assert property (@(posedge clk) disable iff (rst) !(push && full))
    else $error("job pushed into full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) !(pop && empty))
    else $error("job popped from empty queue");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/lgrs_back.sv =====
`default_nettype none

module lgrs_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire lgrs_pkg::job_t  head,
  input  wire                  empty,
  output logic                 pop,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lgrs_pkg::row_t       next_cells,
  output logic                 frame_end
);

  logic           phase;
  logic           do_prev;
  logic           load;
  logic           finish;
  lgrs_pkg::row_t res_next;

  // pick the result for this cycle and evolve it
  always_comb begin
    do_prev = head.has_prev && !phase;
    load    = !empty && (!out_valid || !out_stall);
    finish  = !do_prev || !head.last;
    pop     = load && finish;
    if (do_prev) begin
      res_next = lgrs_pkg::evolve_row(head.up, head.mid, head.down, head.mask);
    end else begin
      res_next = lgrs_pkg::evolve_row(head.mid, head.down, '0, head.mask);
    end
  end

  // output register and job phase
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      phase     <= 1'b0;
    end else begin
      if (load) begin
        out_valid <= 1'b1;
        phase     <= !finish;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      next_cells <= res_next;
      frame_end  <= !do_prev;
    end
  end

`ifndef SYNTHESIS
  a_phase_job: assert property (@(posedge clk) disable iff (rst)
      phase |-> (!empty && head.has_prev && head.last))
    else $error("second result pending without a two-result job");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/life_generation_row_stencil.sv =====
`default_nettype none

// channel   direction  handshake             payload
// config    in         cfg_we                cfg_wdata (grid_width)
// rows      in         in_valid / in_stall   row_cells, last_row
// results   out        out_valid / out_stall next_cells, frame_end
//
// one row item a cycle enters while in_stall is low; each result row takes
// its own turn in the evolve unit, so a last row with a row above yields
// two result rows. results leave through a registered output in the cycle
// after leaving the two-entry job queue. rst is synchronous: clears row
// history, width to 64. in_stall rises only when the job queue is full.

module life_generation_row_stencil (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  cfg_we,
  input  wire lgrs_pkg::width_t cfg_wdata,
  input  wire                  in_valid,
  output logic                 in_stall,
  input  wire lgrs_pkg::row_t  row_cells,
  input  wire                  last_row,
  output logic                 out_valid,
  input  wire                  out_stall,
  output lgrs_pkg::row_t       next_cells,
  output logic                 frame_end
);

  logic           push;
  lgrs_pkg::job_t push_job;
  logic           q_full;
  logic           pop;
  lgrs_pkg::job_t head;
  logic           q_empty;

  // row history and job build
  lgrs_front u_front (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .row_cells (row_cells),
    .last_row  (last_row),
    .push      (push),
    .push_job  (push_job),
    .q_full    (q_full)
  );

  // job queue
  lgrs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (pop),
    .head     (head),
    .empty    (q_empty)
  );

  // evolve unit and output register
  lgrs_back u_back (
    .clk        (clk),
    .rst        (rst),
    .head       (head),
    .empty      (q_empty),
    .pop        (pop),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_cells (next_cells),
    .frame_end  (frame_end)
  );

endmodule

`default_nettype wire

// ===== tb/tb_life_generation_row_stencil.sv =====
module tb_life_generation_row_stencil;

  localparam int ROW_ITEMS     = 1700;
  localparam int QUIET_TAIL    = 150;
  localparam int CYCLE_LIMIT   = 600000;
  localparam int SETTLE_CYCLES = 8;
  localparam int MAX_REPORTS   = 10;

  // one next-generation row as the block should deliver it
  typedef struct {
    lgrs_pkg::row_t cells;
    logic frame_end;
  } gen_row_t;

  // tracks the generation state and the rows still owed by the block
  class next_gen_rows;
    lgrs_pkg::width_t width;
    lgrs_pkg::row_t   above;
    lgrs_pkg::row_t   two_above;
    int unsigned      rows_in_frame;
    gen_row_t         pending_rows[$];
    int unsigned      mismatches;

    function new();
      width = lgrs_pkg::width_t'(lgrs_pkg::MAX_WIDTH);
      above = '0;
      two_above = '0;
      rows_in_frame = 0;
      mismatches = 0;
    endfunction

    // ones in every column below the configured width
    function lgrs_pkg::row_t width_mask();
      lgrs_pkg::row_t m;
      m = '0;
      for (int c = 0; c < lgrs_pkg::MAX_WIDTH; c++) begin
        if (c < int'(width)) m[c] = 1'b1;
      end
      return m;
    endfunction

    // b3/s23 on one row, dead cells past either edge
    function lgrs_pkg::row_t evolve_cells(lgrs_pkg::row_t up, lgrs_pkg::row_t mid,
                                          lgrs_pkg::row_t down, lgrs_pkg::row_t mask);
      logic [lgrs_pkg::MAX_WIDTH+1:0] pu;
      logic [lgrs_pkg::MAX_WIDTH+1:0] pm;
      logic [lgrs_pkg::MAX_WIDTH+1:0] pd;
      lgrs_pkg::row_t res;
      int n;
      pu = {1'b0, up & mask, 1'b0};
      pm = {1'b0, mid & mask, 1'b0};
      pd = {1'b0, down & mask, 1'b0};
      res = '0;
      for (int c = 0; c < lgrs_pkg::MAX_WIDTH; c++) begin
        n = int'(pu[c]) + int'(pu[c+1]) + int'(pu[c+2])
          + int'(pd[c]) + int'(pd[c+1]) + int'(pd[c+2])
          + int'(pm[c]) + int'(pm[c+2]);
        res[c] = (n == 3) || ((n == 2) && pm[c+1]);
      end
      return res & mask;
    endfunction

    // accepted input row: queue the rows it completes, then shift history
    function void take_row(lgrs_pkg::row_t row, logic last);
      lgrs_pkg::row_t mask;
      lgrs_pkg::row_t r;
      gen_row_t g;
      mask = width_mask();
      r = row & mask;
      if (rows_in_frame >= 1) begin
        g.cells = evolve_cells((rows_in_frame >= 2) ? two_above : '0, above, r, mask);
        g.frame_end = 1'b0;
        pending_rows.push_back(g);
      end
      if (last) begin
        g.cells = evolve_cells((rows_in_frame >= 1) ? above : '0, r, '0, mask);
        g.frame_end = 1'b1;
        pending_rows.push_back(g);
        above = '0;
        two_above = '0;
        rows_in_frame = 0;
      end else begin
        two_above = above;
        above = r;
        if (rows_in_frame < 2) rows_in_frame++;
      end
    endfunction

    function void flag(string msg);
      mismatches++;
      if (mismatches <= MAX_REPORTS) $display("mismatch: %s", msg);
    endfunction

    // accepted result row against the oldest owed row
    function void match_row(lgrs_pkg::row_t cells, logic fe);
      gen_row_t g;
      if (pending_rows.size() == 0) begin
        flag($sformatf("unexpected row next_cells %h frame_end %b", cells, fe));
        return;
      end
      g = pending_rows.pop_front();
      if (cells !== g.cells)
        flag($sformatf("next_cells expected %h got %h", g.cells, cells));
      if (fe !== g.frame_end)
        flag($sformatf("frame_end expected %b got %b", g.frame_end, fe));
    endfunction

    function int unsigned pending();
      return pending_rows.size();
    endfunction
  endclass

  logic             clk;
  logic             rst = 1'b1;
  logic             cfg_we = 1'b0;
  lgrs_pkg::width_t cfg_wdata = '0;
  logic             in_valid = 1'b0;
  logic             in_stall;
  lgrs_pkg::row_t   row_cells = '0;
  logic             last_row = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  lgrs_pkg::row_t   next_cells;
  logic             frame_end;

  next_gen_rows book;
  int unsigned  rows_sent = 0;
  int unsigned  tx_idle_pct = 0;
  int unsigned  rx_idle_pct = 0;
  bit           quiet = 1'b0;
  int unsigned  cycle_count = 0;

  life_generation_row_stencil DUT (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .row_cells  (row_cells),
    .last_row   (last_row),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .next_cells (next_cells),
    .frame_end  (frame_end)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb_life_generation_row_stencil NOT OK");
    $finish;
  end

  // result side: check accepted rows, stall in random bursts
  initial begin
    int unsigned stall_left;
    stall_left = 0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && !out_stall) book.match_row(next_cells, frame_end);
      if (quiet) begin
        stall_left = 0;
        out_stall <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < rx_idle_pct) begin
        stall_left = $urandom_range(1, 17) - 1;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // one row item, after an optional idle burst
  task automatic send_row(input lgrs_pkg::row_t row, input logic last);
    int unsigned gap;
    gap = 0;
    if (!quiet && $urandom_range(0, 99) < tx_idle_pct) gap = $urandom_range(1, 17);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    row_cells <= row;
    last_row <= last;
    do @(posedge clk); while (in_stall);
    book.take_row(row, last);
    rows_sent++;
  endtask

  // hold the row side until every owed row is out and the pipe is empty
  task automatic drain_results();
    in_valid <= 1'b0;
    while (book.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_width(input lgrs_pkg::width_t w);
    drain_results();
    cfg_we <= 1'b1;
    cfg_wdata <= w;
    @(posedge clk);
    book.width = w;
    cfg_we <= 1'b0;
  endtask

  function automatic lgrs_pkg::row_t random_row();
    lgrs_pkg::row_t a;
    lgrs_pkg::row_t b;
    lgrs_pkg::row_t c;
    a = {$urandom, $urandom};
    b = {$urandom, $urandom};
    c = {$urandom, $urandom};
    case ($urandom_range(0, 7))
      0: return '0;
      1: return '1;
      2: return a & b & c;
      3: return a | b;
      4: return a & b;
      default: return a;
    endcase
  endfunction

  function automatic lgrs_pkg::width_t random_width();
    case ($urandom_range(0, 7))
      0: return lgrs_pkg::width_t'(0);
      1: return lgrs_pkg::width_t'(1);
      2: return lgrs_pkg::width_t'(lgrs_pkg::MAX_WIDTH);
      3: return lgrs_pkg::width_t'($urandom_range(lgrs_pkg::MAX_WIDTH + 1, 127));
      default: return lgrs_pkg::width_t'($urandom_range(2, lgrs_pkg::MAX_WIDTH - 1));
    endcase
  endfunction

  function automatic int unsigned random_idle_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 5;
      2: return 25;
      default: return 50;
    endcase
  endfunction

  // stimulus
  initial begin
    int unsigned target;
    int unsigned height;
    book = new();
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // single-row grids at full width
    send_row('1, 1'b1);
    send_row('0, 1'b1);
    send_row(64'h8000_0000_0000_0001, 1'b1);
    // taller frame with cells on both edge columns
    send_row(64'h8000_0000_0000_0001, 1'b0);
    send_row(64'hC000_0000_0000_0003, 1'b0);
    send_row(64'h0000_0000_0000_0E00, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // two-row frame
    send_row(64'h0000_0000_0000_0007, 1'b0);
    send_row(64'h0000_0000_0000_0007, 1'b1);
    // checkerboard
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b0);
    send_row(64'h5555_5555_5555_5555, 1'b0);
    send_row(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
    // one column in use
    write_width(lgrs_pkg::width_t'(1));
    send_row('1, 1'b0);
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // zero width kills everything
    write_width(lgrs_pkg::width_t'(0));
    send_row('1, 1'b0);
    send_row('1, 1'b1);
    // width past the row size saturates
    write_width(lgrs_pkg::width_t'(127));
    send_row('1, 1'b0);
    send_row(64'h0F0F_0F0F_0F0F_0F0F, 1'b1);
    // width change in the middle of a frame
    write_width(lgrs_pkg::width_t'(lgrs_pkg::MAX_WIDTH));
    send_row('1, 1'b0);
    send_row(64'hFFFF_0000_FFFF_0000, 1'b0);
    write_width(lgrs_pkg::width_t'(10));
    send_row('1, 1'b0);
    write_width(lgrs_pkg::width_t'(lgrs_pkg::MAX_WIDTH));
    send_row('1, 1'b0);
    send_row('1, 1'b1);

    // random frames
    target = rows_sent + ROW_ITEMS;
    while (rows_sent < target) begin
      quiet = (target - rows_sent <= QUIET_TAIL);
      tx_idle_pct = random_idle_pct();
      rx_idle_pct = random_idle_pct();
      if (!quiet && $urandom_range(0, 99) < 15) write_width(random_width());
      if (!quiet && $urandom_range(0, 99) < 4) drain_results();
      case ($urandom_range(0, 9))
        0: height = 1;
        1: height = 2;
        8: height = $urandom_range(11, 40);
        9: height = 3;
        default: height = $urandom_range(3, 10);
      endcase
      for (int r = 0; r < height; r++) begin
        send_row(random_row(), r == height - 1);
        if (!quiet && r != height - 1 && $urandom_range(0, 99) < 2)
          write_width(random_width());
      end
    end

    // wind down
    quiet = 1'b1;
    in_valid <= 1'b0;
    while (book.pending() > 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (book.mismatches == 0 && book.pending() == 0) begin
      $display("tb_life_generation_row_stencil OK");
    end else begin
      $display("tb_life_generation_row_stencil NOT OK");
    end
    $finish;
  end

endmodule
